// ===== rtl/cerb_pkg.sv =====
// ----------------------------------------------------------------------------
// cerb_pkg
// shared types, character codes and sequencer states of the console echo core
// ----------------------------------------------------------------------------
package cerb_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [7:0]       byte_t;

  // operation codes
  localparam logic [1:0] OP_RX       = 2'd0;
  localparam logic [1:0] OP_TX_READY = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  // character codes
  localparam byte_t CH_BACKSPACE = 8'h08;
  localparam byte_t CH_SPACE     = 8'h20;
  localparam byte_t CH_CR        = 8'h0D;
  localparam byte_t CH_LF        = 8'h0A;

  typedef enum logic [1:0] {
    STEP_HOLD,
    STEP_INC,
    STEP_DEC
  } step_mode_t;

  typedef struct packed {
    step_mode_t mode;
    idx_t       a;
    idx_t       b;
  } step_req_t;

  typedef struct packed {
    idx_t result;
    logic eq;
  } step_rsp_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    byte_t data;
  } ring_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_PUSH,
    S_TX_RD,
    S_IN_STEP,
    S_RD_STEP,
    S_FIN
  } state_t;

endpackage

// ===== rtl/cerb_step_unit.sv =====
// ----------------------------------------------------------------------------
// cerb_step_unit
// shared ring index unit: wrapping increment or decrement plus equality compare
// ----------------------------------------------------------------------------
module cerb_step_unit import cerb_pkg::*; (
  input  step_req_t req,
  output step_rsp_t rsp
);

  idx_t result;

  always_comb begin
    unique case (req.mode)
      STEP_INC: begin
        result = (req.a == idx_t'(RING_DEPTH - 1)) ? '0 : req.a + idx_t'(1);
      end
      STEP_DEC: begin
        result = (req.a == '0) ? idx_t'(RING_DEPTH - 1) : req.a - idx_t'(1);
      end
      default: begin
        result = req.a;
      end
    endcase
  end

  // compare stepped index against the other ring pointer
  assign rsp.result = result;
  assign rsp.eq     = (result == req.b);

endmodule

// ===== rtl/cerb_ring.sv =====
// ----------------------------------------------------------------------------
// cerb_ring
// byte ring storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module cerb_ring import cerb_pkg::*; (
  input  logic     clk,
  input  ring_wr_t wr,
  input  logic     rd_en,
  input  idx_t     rd_addr,
  output byte_t    rd_data
);

  byte_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/console_echo_ring_buffers_core.sv =====
// ----------------------------------------------------------------------------
// console_echo_ring_buffers_core
// console receive and echo engine with an input ring and an echo ring
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | operation, rx_byte
//  out      | out_valid / out_stall| tx_send, tx_byte, line_done,
//           |                      | read_valid, read_byte
//
//  one beat in gives one beat out; the core takes one beat at a time
//  received byte: dispatch, one echo push per cycle (1 to 3 pushes),
//    a transmitter start when idle, then the index step
//  transmitter ready, read: dispatch, ring step unless empty; op 3: dispatch
//  all index arithmetic goes through the single shared step unit
//  rst is synchronous; no clearing pass, ring contents are undefined
//  a waiting result in the output register does not block the next beat in
//
module console_echo_ring_buffers_core import cerb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_send,
  output logic [7:0] tx_byte,
  output logic       line_done,
  output logic       read_valid,
  output logic [7:0] read_byte
);

  state_t state, state_next;

  // captured beat
  logic [1:0] op_q;
  byte_t      chr_q;

  // ring pointers and transmitter flag
  idx_t iwi, iri, owi, ori;
  logic busy;

  // push counter inside one echo sequence
  logic [1:0] cnt;

  // result flags gathered while the beat is worked on
  logic w_tx, w_line, w_rd;

  step_req_t step_req;
  step_rsp_t step_rsp;
  ring_wr_t  in_wr, out_wr;
  logic      in_rd_en, out_rd_en;
  byte_t     in_rd_data, out_rd_data;

  logic       is_bs, is_eol;
  logic [1:0] push_last;
  byte_t      echo_chr;
  logic       in_acc, out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  assign is_bs     = (chr_q == CH_BACKSPACE);
  assign is_eol    = (chr_q == CH_CR) || (chr_q == CH_LF);
  assign push_last = is_bs ? 2'd2 : (is_eol ? 2'd1 : 2'd0);

  // echo characters: "\b \b" for backspace, "\r\n" for end of line
  always_comb begin
    if (is_bs) begin
      echo_chr = (cnt == 2'd1) ? CH_SPACE : CH_BACKSPACE;
    end else if (is_eol) begin
      echo_chr = (cnt == 2'd0) ? CH_CR : CH_LF;
    end else begin
      echo_chr = chr_q;
    end
  end

  cerb_step_unit u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  cerb_ring u_in_ring (
    .clk     (clk),
    .wr      (in_wr),
    .rd_en   (in_rd_en),
    .rd_addr (iri),
    .rd_data (in_rd_data)
  );

  cerb_ring u_out_ring (
    .clk     (clk),
    .wr      (out_wr),
    .rd_en   (out_rd_en),
    .rd_addr (ori),
    .rd_data (out_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, step unit request, ring ports
  always_comb begin
    state_next    = state;
    step_req.mode = STEP_HOLD;
    step_req.a    = owi;
    step_req.b    = ori;
    in_wr.en      = 1'b0;
    in_wr.addr    = iwi;
    in_wr.data    = is_eol ? '0 : chr_q;
    out_wr.en     = 1'b0;
    out_wr.addr   = owi;
    out_wr.data   = echo_chr;
    in_rd_en      = 1'b0;
    out_rd_en     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (op_q)
          OP_RX: begin
            state_next = S_PUSH;
          end
          OP_TX_READY: begin
            // echo ring empty check
            step_req.a = owi;
            step_req.b = ori;
            state_next = step_rsp.eq ? S_FIN : S_TX_RD;
          end
          OP_READ: begin
            step_req.a = iri;
            step_req.b = iwi;
            in_rd_en   = !step_rsp.eq;
            state_next = step_rsp.eq ? S_FIN : S_RD_STEP;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_PUSH: begin
        // the stored byte goes in with the first echo push
        in_wr.en      = (cnt == 2'd0);
        out_wr.en     = 1'b1;
        step_req.mode = STEP_INC;
        step_req.a    = owi;
        step_req.b    = ori;
        if (cnt == push_last) begin
          state_next = busy ? S_IN_STEP : S_TX_RD;
        end
      end
      S_TX_RD: begin
        out_rd_en     = 1'b1;
        step_req.mode = STEP_INC;
        step_req.a    = ori;
        step_req.b    = owi;
        state_next    = (op_q == OP_RX) ? S_IN_STEP : S_FIN;
      end
      S_IN_STEP: begin
        step_req.mode = is_bs ? STEP_DEC : STEP_INC;
        step_req.a    = iwi;
        step_req.b    = iri;
        state_next    = S_FIN;
      end
      S_RD_STEP: begin
        step_req.mode = STEP_INC;
        step_req.a    = iri;
        step_req.b    = iwi;
        state_next    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // beat capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q  <= operation;
      chr_q <= rx_byte;
    end
  end

  // pointer updates from the shared step unit, plus flag and counter updates
  always_ff @(posedge clk) begin
    if (rst) begin
      iwi    <= '0;
      iri    <= '0;
      owi    <= '0;
      ori    <= '0;
      busy   <= 1'b1;
      cnt    <= '0;
      w_tx   <= 1'b0;
      w_line <= 1'b0;
      w_rd   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cnt    <= '0;
            w_tx   <= 1'b0;
            w_line <= 1'b0;
            w_rd   <= 1'b0;
          end
        end
        S_DISPATCH: begin
          if (op_q == OP_TX_READY && step_rsp.eq) begin
            busy <= 1'b0;
          end
          if (op_q == OP_READ && !step_rsp.eq) begin
            w_rd <= 1'b1;
          end
        end
        S_PUSH: begin
          // overrun: a push that would reach the read pointer keeps the last slot
          if (!step_rsp.eq) begin
            owi <= step_rsp.result;
          end
          cnt <= cnt + 2'd1;
        end
        S_TX_RD: begin
          ori  <= step_rsp.result;
          busy <= 1'b1;
          w_tx <= 1'b1;
        end
        S_IN_STEP: begin
          if (is_bs || !step_rsp.eq) begin
            iwi <= step_rsp.result;
          end
          w_line <= is_eol;
        end
        S_RD_STEP: begin
          iri <= step_rsp.result;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      tx_send    <= w_tx;
      tx_byte    <= w_tx ? out_rd_data : '0;
      line_done  <= w_line;
      read_valid <= w_rd;
      read_byte  <= w_rd ? in_rd_data : '0;
    end
  end

  // pointers stay inside the ring
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (int'(iwi) < RING_DEPTH) && (int'(iri) < RING_DEPTH) &&
    (int'(owi) < RING_DEPTH) && (int'(ori) < RING_DEPTH))
    else $error("ring pointer out of range");

  // an echo push never leaves the echo ring looking empty
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |=> (owi != ori))
    else $error("echo push left write pointer on read pointer");

  // a byte handed to the transmitter marks it busy
  a_tx_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && w_tx) |-> busy)
    else $error("transmit without busy flag");

  // end of line and ring read come from different operations
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(line_done && read_valid))
    else $error("line_done and read_valid together");

  // a read result only follows a read request
  a_rd_op: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && w_rd) |-> (op_q == OP_READ))
    else $error("read result without read operation");

endmodule
